FILE: rtl/core/dmpid_pkg.sv
// Shared types, constants and saturating arithmetic for the dual-mode PID core.
`default_nettype none

package dmpid_pkg;

  // Sample and gain formats
  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 32;
  localparam int ERR_W          = SAMPLE_WIDTH + 1;   // setpoint - measured
  localparam int OPD_W          = SAMPLE_WIDTH + 3;   // e0 - 2*e1 + e2 worst case
  localparam int PROD_W         = GAIN_W + OPD_W;     // gain * operand, never overflows
  localparam int ACC_W          = 64;
  localparam int MAG_W          = ACC_W - GAIN_FRAC_BITS;
  localparam int LIMIT_W        = 31;
  localparam int DRIVE_W        = 32;

  // Configuration bus
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;

  // Drive saturation points, as integer magnitudes
  localparam logic [MAG_W-1:0] DRIVE_POS_MAG = MAG_W'((64'd1 << (DRIVE_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] DRIVE_NEG_MAG = MAG_W'(64'd1 << (DRIVE_W - 1));
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Control law selection
  localparam logic MODE_INCR = 1'b0;
  localparam logic MODE_POS  = 1'b1;

  // Register map, word index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_KP        = 3'd1,
    REG_KI        = 3'd2,
    REG_KD        = 3'd3,
    REG_CLAMP_EN  = 3'd4,
    REG_OUT_LIMIT = 3'd5
  } reg_idx_t;

  localparam logic [DATA_W-1:0] MODE_RST      = DATA_W'(1);
  localparam logic [DATA_W-1:0] OUT_LIMIT_RST = DATA_W'(9999);

  // Configuration seen by the datapath
  typedef struct packed {
    logic                      mode;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic                      clamp_en;
    logic [LIMIT_W-1:0]        out_limit;
  } cfg_t;

  // Error stage to product stage
  typedef struct packed {
    logic signed [ERR_W-1:0] e0;
    logic signed [OPD_W-1:0] p_opd;
    logic signed [OPD_W-1:0] d_opd;
  } err_t;

  // Product stage to accumulate stage
  typedef struct packed {
    logic signed [PROD_W-1:0] pt;
    logic signed [PROD_W-1:0] it;
    logic signed [PROD_W-1:0] dt;
  } prod_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] val;
  } sat_t;

  // Signed add that sticks at the 64-bit limits
  function automatic sat_t sat_add(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    sat_t r;
    s = a + b;
    r.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    r.val = r.ovf ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dual_mode_pid_controller_core.sv
// Top level of the dual-mode PID core: pipeline control and stage wiring.
`default_nettype none

// Each request carries a setpoint and a measurement and yields one result
// (drive, clamped). The core is a three-stage pipeline (error and operand
// forming, the three gain multiplies, then saturating accumulate, clamp and
// drive conversion); one request is taken every cycle while the output side
// keeps up, the rate being set by the accumulator update in the last stage.
// A held result stalls only as far back as the pipeline is full. Gains,
// mode, clamp enable and limit are written over the APB port, at byte
// address 4 times the register index; the user must write them only while
// no request is in flight, since the block itself does not enforce it.
module dual_mode_pid_controller_core
  import dmpid_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_setpoint,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_measured,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [DRIVE_W-1:0]           out_drive,
  output logic                                out_clamped,
  // configuration
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [ADDR_W-1:0]              cfg_paddr,
  input  wire logic [DATA_W-1:0]              cfg_pwdata,
  output logic      [DATA_W-1:0]              cfg_prdata,
  output logic                                cfg_pready
);

  cfg_t  cfg;
  err_t  err;
  prod_t prod;

  logic v_err_r, v_err_nxt;
  logic v_mul_r, v_mul_nxt;
  logic out_valid_r, out_valid_nxt;
  logic rdy_err, rdy_mul, rdy_out;
  logic ld_err, ld_mul, ld_out;

  // Stage moves when it is empty or its contents move on
  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy_mul = !v_mul_r || rdy_out;
  assign rdy_err = !v_err_r || rdy_mul;

  assign ld_err = in_valid && rdy_err;
  assign ld_mul = v_err_r && rdy_mul;
  assign ld_out = v_mul_r && rdy_out;

  assign v_err_nxt     = rdy_err ? in_valid : v_err_r;
  assign v_mul_nxt     = rdy_mul ? v_err_r  : v_mul_r;
  assign out_valid_nxt = rdy_out ? v_mul_r  : out_valid_r;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_err_r     <= 1'b0;
      v_mul_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_err_r     <= v_err_nxt;
      v_mul_r     <= v_mul_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !rdy_err;
  assign out_valid = out_valid_r;

  dmpid_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dmpid_err u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld_err),
    .mode     (cfg.mode),
    .setpoint (in_setpoint),
    .measured (in_measured),
    .err      (err)
  );

  dmpid_mul u_mul (
    .clk  (clk),
    .ld   (ld_mul),
    .cfg  (cfg),
    .err  (err),
    .prod (prod)
  );

  dmpid_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld      (ld_out),
    .cfg     (cfg),
    .prod    (prod),
    .drive   (out_drive),
    .clamped (out_clamped)
  );

`ifndef ASSERT_OFF
  // An empty first stage never pushes back on requests
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v_err_r |-> !in_stall)
    else $error("request stalled with empty error stage");

  // A taken request occupies the first stage next cycle
  a_req_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_err_r)
    else $error("taken request lost before error stage");

  // A delivered result with nothing behind it leaves the output empty
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !v_mul_r) |=> !out_valid)
    else $error("result produced without a request behind it");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dmpid_regs.sv
// APB-style configuration registers of the PID core.
`default_nettype none

module dmpid_regs
  import dmpid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_RST[0];
      cfg_r.kp        <= '0;
      cfg_r.ki        <= '0;
      cfg_r.kd        <= '0;
      cfg_r.clamp_en  <= 1'b0;
      cfg_r.out_limit <= OUT_LIMIT_RST[LIMIT_W-1:0];
    end else if (wr_en) begin
      case (idx)
        REG_MODE:      cfg_r.mode      <= cfg_pwdata[0];
        REG_KP:        cfg_r.kp        <= signed'(cfg_pwdata);
        REG_KI:        cfg_r.ki        <= signed'(cfg_pwdata);
        REG_KD:        cfg_r.kd        <= signed'(cfg_pwdata);
        REG_CLAMP_EN:  cfg_r.clamp_en  <= cfg_pwdata[0];
        REG_OUT_LIMIT: cfg_r.out_limit <= cfg_pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (idx)
      REG_MODE:      cfg_prdata = DATA_W'(cfg_r.mode);
      REG_KP:        cfg_prdata = cfg_r.kp;
      REG_KI:        cfg_prdata = cfg_r.ki;
      REG_KD:        cfg_prdata = cfg_r.kd;
      REG_CLAMP_EN:  cfg_prdata = DATA_W'(cfg_r.clamp_en);
      REG_OUT_LIMIT: cfg_prdata = DATA_W'(cfg_r.out_limit);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/dmpid_err.sv
// Error stage: forms the new error and the gain operands, keeps error history.
`default_nettype none

module dmpid_err
  import dmpid_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           ld,
  input  wire logic                           mode,
  input  wire logic signed [SAMPLE_WIDTH-1:0] setpoint,
  input  wire logic signed [SAMPLE_WIDTH-1:0] measured,
  output err_t                                err
);

  logic signed [ERR_W-1:0] prev_error_r;
  logic signed [ERR_W-1:0] prev_prev_error_r;
  logic signed [ERR_W-1:0] e0;
  logic signed [OPD_W-1:0] e0x, e1x, e2x;
  err_t                    err_nxt;
  err_t                    err_r;

  // Operands: incremental uses first and second differences,
  // positional uses the error and its first difference
  always_comb begin
    e0  = ERR_W'(setpoint) - ERR_W'(measured);
    e0x = OPD_W'(e0);
    e1x = OPD_W'(prev_error_r);
    e2x = OPD_W'(prev_prev_error_r);
    err_nxt.e0 = e0;
    if (mode == MODE_INCR) begin
      err_nxt.p_opd = e0x - e1x;
      err_nxt.d_opd = e0x - (e1x <<< 1) + e2x;
    end else begin
      err_nxt.p_opd = e0x;
      err_nxt.d_opd = e0x - e1x;
    end
  end

  // Error history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r      <= '0;
      prev_prev_error_r <= '0;
    end else if (ld) begin
      prev_error_r      <= e0;
      prev_prev_error_r <= prev_error_r;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (ld) begin
      err_r <= err_nxt;
    end
  end

  assign err = err_r;

endmodule

`default_nettype wire

FILE: rtl/core/dmpid_mul.sv
// Product stage: the three gain multiplies, registered.
`default_nettype none

module dmpid_mul
  import dmpid_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  ld,
  input  wire cfg_t  cfg,
  input  wire err_t  err,
  output prod_t      prod
);

  prod_t prod_nxt;
  prod_t prod_r;

  // 32 x 19 (32 x 17 for the integral term) signed products, full width so nothing can overflow
  always_comb begin
    prod_nxt.pt = PROD_W'(cfg.kp) * PROD_W'(err.p_opd);
    prod_nxt.it = PROD_W'(cfg.ki) * PROD_W'(err.e0);
    prod_nxt.dt = PROD_W'(cfg.kd) * PROD_W'(err.d_opd);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: rtl/core/dmpid_acc.sv
// Accumulate stage: saturating sums, clamp, drive conversion, result register.
`default_nettype none

module dmpid_acc
  import dmpid_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      ld,
  input  wire cfg_t                      cfg,
  input  wire prod_t                     prod,
  output logic signed [DRIVE_W-1:0]      drive,
  output logic                           clamped
);

  logic signed [ACC_W-1:0]   integral_acc_r, integral_acc_nxt;
  logic signed [ACC_W-1:0]   output_acc_r, output_acc_nxt;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic                      clamped_r, clamped_nxt;

  logic signed [ACC_W-1:0] pt, it, dt, sum3, raw, lim, nlim;
  logic [ACC_W-1:0]        mag;
  logic [MAG_W-1:0]        mag_int;
  sat_t                    s_inc, s_int, s_pi, s_pos;
  logic                    ovf, hit, dsat;

  always_comb begin
    pt   = ACC_W'(prod.pt);
    it   = ACC_W'(prod.it);
    dt   = ACC_W'(prod.dt);
    // Three terms are far below 2^63, so the pre-sum cannot wrap
    sum3 = pt + it + dt;

    s_inc = sat_add(output_acc_r, sum3);
    s_int = sat_add(integral_acc_r, it);
    s_pi  = sat_add(pt, s_int.val);
    s_pos = sat_add(s_pi.val, dt);

    if (cfg.mode == MODE_INCR) begin
      raw              = s_inc.val;
      ovf              = s_inc.ovf;
      integral_acc_nxt = integral_acc_r;
    end else begin
      raw              = s_pos.val;
      ovf              = s_int.ovf | s_pi.ovf | s_pos.ovf;
      integral_acc_nxt = s_int.val;
    end

    // Clamp to +-limit in fixed-point scale; touching the limit counts
    lim  = ACC_W'(cfg.out_limit) <<< GAIN_FRAC_BITS;
    nlim = -lim;
    hit  = 1'b0;
    output_acc_nxt = raw;
    if (cfg.clamp_en) begin
      if (raw >= lim) begin
        output_acc_nxt = lim;
        hit = 1'b1;
      end else if (raw <= nlim) begin
        output_acc_nxt = nlim;
        hit = 1'b1;
      end
    end

    // Integer part toward zero, saturated to 32 bits
    mag     = output_acc_nxt[ACC_W-1] ? -output_acc_nxt : output_acc_nxt;
    mag_int = mag[ACC_W-1:GAIN_FRAC_BITS];
    if (output_acc_nxt[ACC_W-1]) begin
      dsat      = mag_int > DRIVE_NEG_MAG;
      drive_nxt = dsat ? DRIVE_MIN : -signed'(mag_int[DRIVE_W-1:0]);
    end else begin
      dsat      = mag_int > DRIVE_POS_MAG;
      drive_nxt = dsat ? DRIVE_MAX : signed'(mag_int[DRIVE_W-1:0]);
    end
    clamped_nxt = ovf | hit | dsat;
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_acc_r <= '0;
      output_acc_r   <= '0;
    end else if (ld) begin
      integral_acc_r <= integral_acc_nxt;
      output_acc_r   <= output_acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ld) begin
      drive_r   <= drive_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign drive   = drive_r;
  assign clamped = clamped_r;

endmodule

`default_nettype wire
